// ----- rtl/frl_pkg.sv -----
// frl_pkg: shared constants and types for the recent identifier list.
// No dependencies; used by frl_store, fifo_recent_id_list_unit and the testbench.
package frl_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int IDENT_BITS_DEF  = 32;

    localparam int          CFG_W     = 5;
    localparam logic [4:0]  CAP_RESET = 5'd16;

    typedef struct packed {
        logic ins;   // accepted beat: insert ident if not held
        logic clr;   // batch end: count drops to zero
        logic pop;   // readout: shift list toward the front
    } frl_ctl_t;

endpackage

// ----- rtl/frl_store.sv -----
// frl_store: row of identifier cells with parallel match and FIFO replacement.
// Depends on frl_pkg.
module frl_store #(
    parameter int MAX_ENTRIES = frl_pkg::MAX_ENTRIES_DEF,
    parameter int IDENT_BITS  = frl_pkg::IDENT_BITS_DEF,
    parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  frl_pkg::frl_ctl_t        ctl,
    input  logic [frl_pkg::CFG_W-1:0] capacity,
    input  logic [IDENT_BITS-1:0]    ident,
    output logic [CNT_W-1:0]         acc_count,
    output logic [IDENT_BITS-1:0]    head_ident
);
    import frl_pkg::*;

    localparam int CW = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [CW-1:0] MAX_W = CW'(MAX_ENTRIES);

    logic [IDENT_BITS-1:0] cell_reg [MAX_ENTRIES];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    logic [MAX_ENTRIES-1:0] match;
    logic                   hit;
    logic [CW-1:0]          cap_w;
    logic [CW-1:0]          cap_eff;
    logic [CW-1:0]          count_w;
    logic [CW-1:0]          keep;
    logic [CNT_W-1:0]       ins_count;

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            match[i] = (CNT_W'(i) < count_reg) && (cell_reg[i] == ident);
        end
    end

    assign hit = |match;

    always_comb
    begin
        cap_w   = CW'(capacity);
        count_w = CW'(count_reg);
        if (cap_w == '0)
            cap_eff = CW'(1);
        else if (cap_w > MAX_W)
            cap_eff = MAX_W;
        else
            cap_eff = cap_w;
        keep = (count_w > cap_eff - CW'(1)) ? cap_eff - CW'(1) : count_w;
    end

    assign ins_count  = CNT_W'(keep + CW'(1));
    assign acc_count  = hit ? count_reg : ins_count;
    assign head_ident = cell_reg[0];

    always_comb
    begin
        if (ctl.clr)
            count_next = '0;
        else if (ctl.ins)
            count_next = acc_count;
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ins && !hit)
        begin
            cell_reg[0] <= ident;
            for (int i = 1; i < MAX_ENTRIES; i++)
                cell_reg[i] <= cell_reg[i-1];
        end
        else if (ctl.pop)
        begin
            for (int i = 0; i < MAX_ENTRIES - 1; i++)
                cell_reg[i] <= cell_reg[i+1];
        end
    end

endmodule

// ----- rtl/fifo_recent_id_list_unit.sv -----
// fifo_recent_id_list_unit: top level of the recent identifier list.
// Depends on frl_pkg and frl_store.
//
// Keeps up to capacity distinct identifiers, newest first, with FIFO
// replacement. One input beat is taken per cycle while in_stall is low; all
// cells are compared in parallel and, on a miss, the list shifts by one in the
// same cycle. A beat with batch_end set is inserted first, then the list is
// read out newest first, one output beat per cycle unless out_stall holds it,
// while input is stalled; input resumes once the last entry is in the output
// register. Capacity 0 acts as 1, values above MAX_ENTRIES as MAX_ENTRIES.
// Write capacity only while the block is idle.
module fifo_recent_id_list_unit #(
    parameter int MAX_ENTRIES = frl_pkg::MAX_ENTRIES_DEF,
    parameter int IDENT_BITS  = frl_pkg::IDENT_BITS_DEF,
    parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [frl_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [IDENT_BITS-1:0]     ident,
    input  logic                      batch_end,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [CNT_W-1:0]          entry_count,
    output logic [IDENT_BITS-1:0]     entry_ident,
    output logic                      final_flag
);
    import frl_pkg::*;

    logic [CFG_W-1:0]      capacity_reg;
    logic [CNT_W-1:0]      rd_left_reg,  rd_left_next;
    logic [CNT_W-1:0]      rd_total_reg, rd_total_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]      count_reg;
    logic [IDENT_BITS-1:0] ident_reg;
    logic                  final_reg;

    frl_ctl_t              ctl;
    logic                  in_acc;
    logic                  out_free;
    logic                  load;
    logic [CNT_W-1:0]      acc_count;
    logic [IDENT_BITS-1:0] head_ident;

    assign in_stall = (rd_left_reg != '0);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign load     = (rd_left_reg != '0) && out_free;

    assign ctl.ins = in_acc;
    assign ctl.clr = in_acc && batch_end;
    assign ctl.pop = load;

    frl_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IDENT_BITS  (IDENT_BITS),
        .CNT_W       (CNT_W)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .capacity   (capacity_reg),
        .ident      (ident),
        .acc_count  (acc_count),
        .head_ident (head_ident)
    );

    always_comb
    begin
        rd_left_next  = rd_left_reg;
        rd_total_next = rd_total_reg;
        if (ctl.clr)
        begin
            rd_left_next  = acc_count;
            rd_total_next = acc_count;
        end
        else if (load)
        begin
            rd_left_next = rd_left_reg - CNT_W'(1);
        end

        if (load)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            rd_left_reg   <= '0;
            rd_total_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                capacity_reg <= cfg_wr_data;
            rd_left_reg   <= rd_left_next;
            rd_total_reg  <= rd_total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            count_reg <= rd_total_reg;
            ident_reg <= head_ident;
            final_reg <= (rd_left_reg == CNT_W'(1));
        end
    end

    assign out_valid   = out_valid_reg;
    assign entry_count = count_reg;
    assign entry_ident = ident_reg;
    assign final_flag  = final_reg;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for fifo_recent_id_list_unit (recent identifier list).
// Directed table, then random batches, checked against a list model or the table.
// Depends on frl_pkg and the RTL of fifo_recent_id_list_unit.
module testbench;

    localparam int LIST_DEPTH = frl_pkg::MAX_ENTRIES_DEF;
    localparam int ID_W       = frl_pkg::IDENT_BITS_DEF;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int SETTLE     = 4;
    localparam int TAIL       = 20;
    localparam int QUIET_MAX  = 5000;
    localparam int RAND_BEATS = 51;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [ID_W-1:0]  id;
        logic             last;
    } readout_t;

    typedef enum logic {ROW_BEAT, ROW_CAP} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [ID_W-1:0]  val;
        logic             last;
        logic             typed;
        logic [ID_W-1:0]  want;
    } plan_row_t;

    localparam int PLAN_LEN = 24;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{ROW_BEAT, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{ROW_BEAT, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{ROW_BEAT, 32'd5,         1'b0, 1'b0, 32'd0},
        '{ROW_BEAT, 32'd5,         1'b0, 1'b0, 32'd0},
        '{ROW_BEAT, 32'd7,         1'b0, 1'b0, 32'd0},
        '{ROW_BEAT, 32'd5,         1'b1, 1'b0, 32'd0},
        '{ROW_CAP,  32'd0,         1'b0, 1'b0, 32'd0},   // zero acts as one
        '{ROW_BEAT, 32'd1,         1'b0, 1'b0, 32'd0},
        '{ROW_BEAT, 32'd2,         1'b0, 1'b0, 32'd0},
        '{ROW_BEAT, 32'd3,         1'b1, 1'b1, 32'd3},
        '{ROW_CAP,  32'd2,         1'b0, 1'b0, 32'd0},
        '{ROW_BEAT, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'd0},
        '{ROW_BEAT, 32'h5555_5555, 1'b0, 1'b0, 32'd0},
        '{ROW_BEAT, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'd0},
        '{ROW_BEAT, 32'h8000_0000, 1'b1, 1'b0, 32'd0},
        '{ROW_CAP,  32'd31,        1'b0, 1'b0, 32'd0},   // saturates
        '{ROW_BEAT, 32'd20,        1'b0, 1'b0, 32'd0},
        '{ROW_BEAT, 32'd21,        1'b0, 1'b0, 32'd0},
        '{ROW_BEAT, 32'd22,        1'b0, 1'b0, 32'd0},
        '{ROW_BEAT, 32'd23,        1'b0, 1'b0, 32'd0},
        '{ROW_CAP,  32'd2,         1'b0, 1'b0, 32'd0},   // shrink below held count
        '{ROW_BEAT, 32'd21,        1'b0, 1'b0, 32'd0},
        '{ROW_BEAT, 32'd24,        1'b1, 1'b0, 32'd0},
        '{ROW_CAP,  32'd16,        1'b0, 1'b0, 32'd0}
    };

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      cfg_wr_en   = 1'b0;
    logic [frl_pkg::CFG_W-1:0] cfg_wr_data = '0;
    logic                      in_valid    = 1'b0;
    logic                      in_stall;
    logic [ID_W-1:0]           ident       = '0;
    logic                      batch_end   = 1'b0;
    logic                      out_valid;
    logic                      out_stall   = 1'b0;
    logic [CNT_W-1:0]          entry_count;
    logic [ID_W-1:0]           entry_ident;
    logic                      final_flag;

    // list model
    logic [ID_W-1:0]           held_ids [LIST_DEPTH];
    int unsigned               held_n;
    logic [frl_pkg::CFG_W-1:0] cap_reg;
    readout_t                  readout_q [$];

    int send_idle_pct;
    int recv_stall_pct;
    int n_beats;
    int n_readouts;
    int n_cap_writes;
    int n_errs;
    int quiet_cycles;
    readout_t got;
    readout_t want;

    fifo_recent_id_list_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .ident       (ident),
        .batch_end   (batch_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .entry_count (entry_count),
        .entry_ident (entry_ident),
        .final_flag  (final_flag)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic update_list(input logic [ID_W-1:0] id, input logic last,
                               input bit push_en);
        int unsigned cap;
        int unsigned keep;
        bit          hit;
        readout_t    r;
        hit = 1'b0;
        for (int i = 0; i < held_n; i++)
            if (held_ids[i] == id)
                hit = 1'b1;
        if (!hit)
        begin
            cap = (cap_reg == 0) ? 1 : ((cap_reg > LIST_DEPTH) ? LIST_DEPTH : cap_reg);
            keep = (held_n > cap - 1) ? cap - 1 : held_n;
            for (int i = keep; i > 0; i--)
                held_ids[i] = held_ids[i - 1];
            held_ids[0] = id;
            held_n = keep + 1;
        end
        if (last)
        begin
            for (int k = 0; k < held_n; k++)
            begin
                r.count = held_n[CNT_W-1:0];
                r.id    = held_ids[k];
                r.last  = (k + 1 == held_n);
                if (push_en)
                    readout_q = {readout_q, r};
            end
            held_n = 0;
        end
    endtask

    task automatic send_beat(input logic [ID_W-1:0] id, input logic last,
                             input bit push_en);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        ident     <= id;
        batch_end <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        update_list(id, last, push_en);
        n_beats++;
    endtask

    // pause input, let every readout drain, then write capacity
    task automatic write_capacity(input logic [frl_pkg::CFG_W-1:0] val);
        in_valid <= 1'b0;
        while (readout_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cap_reg = val;
        n_cap_writes++;
    endtask

    function automatic logic [frl_pkg::CFG_W-1:0] pick_capacity();
        case ($urandom_range(0, 5))
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'd16;
            3: return 5'd31;
            default: return 5'($urandom_range(0, 31));
        endcase
    endfunction

    task automatic note_mismatch(input string what, input readout_t w, input readout_t g);
        n_errs++;
        if (n_errs <= 10)
            $display("%s: expected count %0d ident %h final %b, got count %0d ident %h final %b",
                     what, w.count, w.id, w.last, g.count, g.id, g.last);
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            n_readouts++;
            got = '{entry_count, entry_ident, final_flag};
            if (readout_q.size() == 0)
                note_mismatch("unexpected beat", '0, got);
            else
            begin
                want = readout_q.pop_front();
                if (got.count !== want.count || got.id !== want.id || got.last !== want.last)
                    note_mismatch("readout mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d readouts pending",
                     QUIET_MAX, readout_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        logic [ID_W-1:0] pool;
        int              len;
        int              left;
        readout_t        r;
        held_n         = 0;
        cap_reg        = frl_pkg::CAP_RESET;
        send_idle_pct  = 36;
        recv_stall_pct = 75;
        n_beats        = 0;
        n_readouts     = 0;
        n_cap_writes   = 0;
        n_errs         = 0;
        quiet_cycles   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (PLAN[i].kind == ROW_CAP)
                write_capacity(PLAN[i].val[frl_pkg::CFG_W-1:0]);
            else
            begin
                if (PLAN[i].typed)
                begin
                    r = '{CNT_W'(1), PLAN[i].want, 1'b1};
                    readout_q = {readout_q, r};
                end
                send_beat(PLAN[i].val, PLAN[i].last, !PLAN[i].typed);
            end
        end

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct  = (mode == 0) ? 36 : ((mode == 1) ? 75 : 0);
            recv_stall_pct = (mode == 0) ? 75 : ((mode == 1) ? 36 : 0);
            write_capacity(pick_capacity());
            left = RAND_BEATS;
            while (left > 0)
            begin
                len  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(1, 20);
                if (len > left)
                    len = left;
                pool = $urandom;
                for (int k = 0; k < len; k++)
                begin
                    if (k > 0 && $urandom_range(0, 15) == 0)
                        write_capacity(pick_capacity());
                    send_beat(($urandom_range(0, 3) == 0) ? ID_W'($urandom)
                                                          : pool + $urandom_range(0, 23),
                              k == len - 1, 1'b1);
                end
                left -= len;
                if ($urandom_range(0, 2) == 0)
                    write_capacity(pick_capacity());
            end
        end

        in_valid <= 1'b0;
        while (readout_q.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
        $display("Covered %0d input beats and %0d readout beats over %0d capacity writes,",
                 n_beats, n_readouts, n_cap_writes);
        $display("three stall profiles, capacity extremes and shrink mid-batch; %0d mismatches",
                 n_errs);
        if (n_errs == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/frl_pkg.sv
rtl/frl_store.sv
rtl/fifo_recent_id_list_unit.sv
verif/testbench.sv
